@@ rtl/deq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes for the double-ended queue.
// No dependencies; imported by deq_ctrl and double_ended_queue.
package deq_pkg;

  // Operation requested by one input item
  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  // Result status reported with each item
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OCC_W   = 5;

  // Control bundle from pointer logic to the datapath
  typedef struct packed {
    logic    we;      // write the entry at addr
    logic    re;      // read the entry at addr
    logic    pop_ok;  // successful pop, data comes from memory
    status_t status;
  } deq_ctl_t;

endpackage
`default_nettype wire

@@ rtl/double_ended_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/in_tready   tuser: kind, tdata: value
// out_     out  out_tvalid/out_tready tuser: status, tdata: popped_value, occupancy
//
// One item per cycle sustained while out_tready is high; out_tvalid rises once
// the item has passed the memory read stage and then the output register.
// Pointer update and the memory access happen at the accept edge, so an item
// may read an entry written by the item just before it.
// Synchronous active-low reset empties the queue; stored values are not cleared.
// A stalled output holds the result register and the read stage, then input.
// Top level of the double-ended queue. Depends on deq_pkg, deq_ram, deq_ctrl.
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // [31:0] popped_value, [36:32] occupancy
  output      logic [1:0]  out_tuser   // [1:0] status
);
  import deq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic               in_acc, adv;
  deq_ctl_t           ctl;
  logic [AW-1:0]      mem_addr;
  logic [CW-1:0]      count_after;
  logic [VALUE_W-1:0] rd_data;

  // Read stage
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_pop_r, s1_pop_nxt;
  status_t       s1_status_r, s1_status_nxt;
  logic [OCC_W-1:0] s1_occ_r, s1_occ_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_data_r, out_data_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [OCC_W-1:0]   out_occ_r, out_occ_nxt;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .kind        (kind_t'(in_tuser)),
    .ctl         (ctl),
    .addr        (mem_addr),
    .count_after (count_after)
  );

  deq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (in_acc && ctl.we),
    .waddr (mem_addr),
    .wdata (in_tdata),
    .re    (in_acc && ctl.re),
    .raddr (mem_addr),
    .rdata (rd_data)
  );

  // Read stage next values
  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    s1_pop_nxt    = in_acc ? ctl.pop_ok : s1_pop_r;
    s1_status_nxt = in_acc ? ctl.status : s1_status_r;
    s1_occ_nxt    = in_acc ? OCC_W'(count_after) : s1_occ_r;
  end

  // Output register next values; failed pops and pushes return zero
  always_comb begin
    out_valid_nxt  = adv ? s1_valid_r : out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    if (adv && s1_valid_r) begin
      out_data_nxt   = s1_pop_r ? rd_data : '0;
      out_status_nxt = s1_status_r;
      out_occ_nxt    = s1_occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_pop_r     <= s1_pop_nxt;
    s1_status_r  <= s1_status_nxt;
    s1_occ_r     <= s1_occ_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_occ_r, out_data_r};
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  // Overflow only happens with a full queue
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == STATUS_OVERFLOW |-> out_occ_r == OCC_W'(DEPTH))
    else $error("overflow reported while queue not full");

  // Underflow only on an empty queue and returns zero
  a_udf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == STATUS_UNDERFLOW |-> out_occ_r == '0 && out_data_r == '0)
    else $error("underflow result not empty or not zero");

  // A blocked read stage keeps its item and its memory data
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(rd_data))
    else $error("read stage lost item or data while stalled");
`endif

endmodule
`default_nettype wire

@@ rtl/deq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/deq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Head pointer and entry count of the ring buffer; picks the memory
// address and access for each item. Depends on deq_pkg.
module deq_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire deq_pkg::kind_t             kind,
  output      deq_pkg::deq_ctl_t          ctl,
  output      logic [$clog2(DEPTH)-1:0]   addr,
  output      logic [$clog2(DEPTH+1)-1:0] count_after
);
  import deq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          full, empty;
  logic [AW-1:0] head_dec, head_inc, back_addr;
  logic [CW-1:0] back_off;
  logic [SW-1:0] back_sum, back_pos;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // Ring arithmetic around the head
  assign head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign back_off  = (kind == KIND_POP_BACK) ? count_r - 1'b1 : count_r;
  assign back_sum  = SW'(head_r) + SW'(back_off);
  assign back_pos  = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;
  assign back_addr = back_pos[AW-1:0];

  // Decode operation
  always_comb begin
    ctl       = '{we: 1'b0, re: 1'b0, pop_ok: 1'b0, status: STATUS_OK};
    addr      = head_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    case (kind)
      KIND_PUSH_FRONT: begin
        if (full) begin
          ctl.status = STATUS_OVERFLOW;
        end else begin
          ctl.we    = 1'b1;
          addr      = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          ctl.status = STATUS_OVERFLOW;
        end else begin
          ctl.we    = 1'b1;
          addr      = back_addr;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          ctl.status = STATUS_UNDERFLOW;
        end else begin
          ctl.re     = 1'b1;
          ctl.pop_ok = 1'b1;
          addr       = head_r;
          head_nxt   = head_inc;
          count_nxt  = count_r - 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          ctl.status = STATUS_UNDERFLOW;
        end else begin
          ctl.re     = 1'b1;
          ctl.pop_ok = 1'b1;
          addr       = back_addr;
          count_nxt  = count_r - 1'b1;
        end
      end
      default: begin
        ctl.status = STATUS_OK;
      end
    endcase
  end

  assign count_after = count_nxt;

  // Pointer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire
